// ===== src/pph_pkg.sv =====
// Shared types and constants for the punch probe header parser.
`timescale 1ns / 1ps
package pph_pkg;

    // Verdict codes
    typedef enum logic [1:0] {
        STATUS_NOT_PROBE = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_REQUEST   = 2'd2,
        STATUS_RESPONSE  = 2'd3
    } status_t;

    // Header layout and field values
    localparam logic [7:0]  PROBE_VERSION  = 8'd1;
    localparam logic [7:0]  TYPE_REQUEST   = 8'd1;
    localparam logic [7:0]  TYPE_RESPONSE  = 8'd2;
    localparam logic [15:0] HDR_BYTES      = 16'd16;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [15:0] MAGIC_BYTES    = 16'd4;
    localparam logic [15:0] POS_VERSION    = 16'd4;
    localparam logic [15:0] POS_TYPE       = 16'd5;
    localparam logic [15:0] POS_LEN_HI     = 16'd6;
    localparam logic [15:0] POS_LEN_LO     = 16'd7;
    localparam logic [15:0] POS_TXN_FIRST  = 16'd8;
    localparam logic [15:0] POS_TXN_LAST   = 16'd11;
    localparam logic [15:0] POS_KEY_LEN    = 16'd12;

    // Magic "fpup", indexed by byte offset
    localparam logic [7:0] MAGIC [4] = '{8'h66, 8'h70, 8'h75, 8'h70};

    // One byte handed to the header capture stage
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } step_t;

    // Verdict produced on the final byte
    typedef struct packed {
        status_t     status;
        logic [31:0] transaction_id;
        logic [7:0]  sender_key_len;
    } verdict_t;

endpackage

// ===== src/pph_in_if.sv =====
// Byte stream channel: one payload byte with a final-byte mark.
`timescale 1ns / 1ps
interface pph_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/pph_out_if.sv =====
// Verdict channel: one probe verdict per payload.
`timescale 1ns / 1ps
interface pph_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  probe_status;
    logic [31:0] transaction_id;
    logic [7:0]  sender_key_len;

    modport source (output valid, output probe_status, output transaction_id,
                    output sender_key_len, input ready);
    modport sink   (input valid, input probe_status, input transaction_id,
                    input sender_key_len, output ready);
endinterface

// ===== src/pph_hdr_capture.sv =====
// Header field capture, byte counter and verdict logic.
`timescale 1ns / 1ps
module pph_hdr_capture (
    input  logic              clk,
    input  logic              rst_n,
    input  pph_pkg::step_t    step,
    output pph_pkg::verdict_t verdict
);
    import pph_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic        magic_match_reg, magic_match_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [31:0] txn_reg, txn_next;
    logic [7:0]  key_len_reg, key_len_next;

    // Field values after this byte is taken in
    logic [15:0] count_cap;
    logic        magic_cap;
    logic [7:0]  version_cap;
    logic [7:0]  type_cap;
    logic [15:0] decl_len_cap;
    logic [31:0] txn_cap;
    logic [7:0]  key_len_cap;
    logic [15:0] pos;
    logic        type_ok;
    logic        probe_ok;

    // Capture the byte at its header offset and advance the counter
    always_comb
    begin
        pos          = byte_count_reg;
        magic_cap    = magic_match_reg;
        version_cap  = version_reg;
        type_cap     = type_reg;
        decl_len_cap = decl_len_reg;
        txn_cap      = txn_reg;
        key_len_cap  = key_len_reg;
        if (pos < MAGIC_BYTES)
        begin
            if (step.data != MAGIC[pos[1:0]])
            begin
                magic_cap = 1'b0;
            end
        end
        else if (pos == POS_VERSION)
        begin
            version_cap = step.data;
        end
        else if (pos == POS_TYPE)
        begin
            type_cap = step.data;
        end
        else if (pos == POS_LEN_HI || pos == POS_LEN_LO)
        begin
            decl_len_cap = {decl_len_reg[7:0], step.data};
        end
        else if (pos >= POS_TXN_FIRST && pos <= POS_TXN_LAST)
        begin
            txn_cap = {txn_reg[23:0], step.data};
        end
        else if (pos == POS_KEY_LEN)
        begin
            key_len_cap = step.data;
        end
        count_cap = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                  : byte_count_reg + 16'd1;
    end

    // Judge the payload from the captured fields
    always_comb
    begin
        type_ok  = (type_cap == TYPE_REQUEST) || (type_cap == TYPE_RESPONSE);
        probe_ok = magic_cap && (version_cap == PROBE_VERSION) && type_ok &&
                   (count_cap != COUNT_MAX) && (decl_len_cap == count_cap) &&
                   (count_cap == HDR_BYTES + {8'd0, key_len_cap});
        if (probe_ok)
        begin
            verdict.status         = (type_cap == TYPE_REQUEST) ? STATUS_REQUEST
                                                                : STATUS_RESPONSE;
            verdict.transaction_id = txn_cap;
            verdict.sender_key_len = key_len_cap;
        end
        else
        begin
            verdict.status         = (count_cap >= MAGIC_BYTES && magic_cap)
                                     ? STATUS_MALFORMED : STATUS_NOT_PROBE;
            verdict.transaction_id = 32'd0;
            verdict.sender_key_len = 8'd0;
        end
    end

    // Hold when idle, clear after the final byte, otherwise keep the capture
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        magic_match_next = magic_match_reg;
        version_next     = version_reg;
        type_next        = type_reg;
        decl_len_next    = decl_len_reg;
        txn_next         = txn_reg;
        key_len_next     = key_len_reg;
        if (step.valid)
        begin
            if (step.last)
            begin
                byte_count_next  = 16'd0;
                magic_match_next = 1'b1;
                version_next     = 8'd0;
                type_next        = 8'd0;
                decl_len_next    = 16'd0;
                txn_next         = 32'd0;
                key_len_next     = 8'd0;
            end
            else
            begin
                byte_count_next  = count_cap;
                magic_match_next = magic_cap;
                version_next     = version_cap;
                type_next        = type_cap;
                decl_len_next    = decl_len_cap;
                txn_next         = txn_cap;
                key_len_next     = key_len_cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 16'd0;
            magic_match_reg <= 1'b1;
            version_reg     <= 8'd0;
            type_reg        <= 8'd0;
            decl_len_reg    <= 16'd0;
            txn_reg         <= 32'd0;
            key_len_reg     <= 8'd0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            magic_match_reg <= magic_match_next;
            version_reg     <= version_next;
            type_reg        <= type_next;
            decl_len_reg    <= decl_len_next;
            txn_reg         <= txn_next;
            key_len_reg     <= key_len_next;
        end
    end

endmodule

// ===== src/punch_probe_header_parser.sv =====
// Top level of the punch probe header parser.
//
// Usage:
//   payload: byte stream sink (data_byte, last_byte); one byte per request.
//     Assert last_byte on the final byte of each UDP payload.
//   verdict: one request per payload, carrying probe_status (0 not a probe,
//     1 malformed probe, 2 valid request, 3 valid response), transaction_id
//     and sender_key_len; the two fields read 0 unless the probe is valid.
// Throughput: one byte per cycle, sustained, while verdicts are taken.
// Verdict path: a final byte passes through an input register, the header
//   capture and judge logic, and the verdict register, and it can wait in
//   the input register while an earlier verdict has not been taken.
// Reset: clears the header capture, the byte counter and both valid flags;
//   the first byte after reset is offset 0 of a payload.
// Stall: a waiting verdict holds stable; ordinary bytes keep flowing, and a
//   further final byte waits in the input register until the verdict is
//   taken, which then backs up the payload channel.
`timescale 1ns / 1ps
module punch_probe_header_parser (
    input logic       clk,
    input logic       rst_n,
    pph_in_if.sink    payload,
    pph_out_if.source verdict
);
    import pph_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    verdict_t   result_reg;
    verdict_t   judged;
    step_t      step;
    logic       step_go;
    logic       in_take;

    // Advance the held byte unless it is a final byte blocked by the output
    assign step_go = in_valid_reg && (!in_last_reg || !out_valid_reg || verdict.ready);
    assign payload.ready = !in_valid_reg || step_go;
    assign in_take = payload.valid && payload.ready;

    assign step.valid = step_go;
    assign step.last  = in_last_reg;
    assign step.data  = in_data_reg;

    pph_hdr_capture u_capture (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .verdict (judged)
    );

    // Valid flags for the input and verdict registers
    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (step_go ? 1'b0 : in_valid_reg);
        if (step_go && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the payload byte registers and, when a final byte steps, the verdict register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= payload.data_byte;
            in_last_reg <= payload.last_byte;
        end
        if (step_go && in_last_reg)
        begin
            result_reg <= judged;
        end
    end

    assign verdict.valid          = out_valid_reg;
    assign verdict.probe_status   = result_reg.status;
    assign verdict.transaction_id = result_reg.transaction_id;
    assign verdict.sender_key_len = result_reg.sender_key_len;

endmodule

// ===== src/pph_checker.sv =====
// Port-level assertions for the punch probe header parser, with its bind.
`timescale 1ns / 1ps
module pph_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic [31:0] out_txn,
    input logic [7:0]  out_key_len
);
    import pph_pkg::*;

    // A stalled verdict holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) &&
        $stable(out_txn) && $stable(out_key_len))
        else $error("stalled verdict changed");

    // Rejected payloads report zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == STATUS_NOT_PROBE || out_status == STATUS_MALFORMED)
        |-> out_txn == 32'd0 && out_key_len == 8'd0)
        else $error("rejected verdict carries nonzero fields");

    // No verdict during reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("verdict valid during reset");

endmodule

bind punch_probe_header_parser pph_checker u_pph_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (verdict.valid),
    .out_ready   (verdict.ready),
    .out_status  (verdict.probe_status),
    .out_txn     (verdict.transaction_id),
    .out_key_len (verdict.sender_key_len)
);

// ===== tb/sv/punch_probe_header_parser_test.sv =====
// Self-checking testbench for the punch probe header parser.
`timescale 1ns / 1ps
module punch_probe_header_parser_test;
    import pph_pkg::*;

    localparam logic [31:0] PROBE_MAGIC = {MAGIC[0], MAGIC[1], MAGIC[2], MAGIC[3]};
    localparam int RANDOM_BYTES = 1260;

    // Random packet shapes
    typedef enum int {
        PK_GOOD,
        PK_BAD_MAGIC,
        PK_BAD_VERSION,
        PK_BAD_TYPE,
        PK_BAD_LENGTH,
        PK_BAD_KEYLEN,
        PK_SHORT,
        PK_LONG,
        PK_NOISE
    } packet_kind_t;

    // One payload byte waiting to be sent
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } payload_byte_t;

    logic clk;
    logic rst_n;

    pph_in_if  payload_if ();
    pph_out_if verdict_if ();

    punch_probe_header_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload_if),
        .verdict (verdict_if)
    );

    payload_byte_t byte_queue[$];
    verdict_t      verdict_queue[$];

    // Header capture state of the predictor
    logic [15:0] seen_count;
    logic        magic_ok;
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_kind;
    logic [15:0] hdr_length;
    logic [31:0] hdr_txn;
    logic [7:0]  hdr_key_len;

    int          mismatch_count;
    bit          in_taken;
    logic [31:0] cycle_cnt;
    int          burst_left;
    int          gap_left;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task automatic clear_header();
        seen_count  = '0;
        magic_ok    = 1'b1;
        hdr_version = '0;
        hdr_kind    = '0;
        hdr_length  = '0;
        hdr_txn     = '0;
        hdr_key_len = '0;
    endtask

    // Capture one byte and, on the final byte, queue the verdict it yields
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [15:0] pos;
        logic        ok;
        verdict_t    v;
        pos = seen_count;
        if (pos < MAGIC_BYTES)
        begin
            if (b != MAGIC[pos[1:0]])
                magic_ok = 1'b0;
        end
        else if (pos == POS_VERSION)
            hdr_version = b;
        else if (pos == POS_TYPE)
            hdr_kind = b;
        else if (pos == POS_LEN_HI || pos == POS_LEN_LO)
            hdr_length = {hdr_length[7:0], b};
        else if (pos >= POS_TXN_FIRST && pos <= POS_TXN_LAST)
            hdr_txn = {hdr_txn[23:0], b};
        else if (pos == POS_KEY_LEN)
            hdr_key_len = b;
        if (seen_count != COUNT_MAX)
            seen_count = seen_count + 16'd1;
        if (fin)
        begin
            ok = magic_ok && hdr_version == PROBE_VERSION &&
                 (hdr_kind == TYPE_REQUEST || hdr_kind == TYPE_RESPONSE) &&
                 seen_count != COUNT_MAX && hdr_length == seen_count &&
                 (HDR_BYTES + {8'd0, hdr_key_len}) == seen_count;
            if (ok)
            begin
                v.status         = (hdr_kind == TYPE_REQUEST) ? STATUS_REQUEST
                                                              : STATUS_RESPONSE;
                v.transaction_id = hdr_txn;
                v.sender_key_len = hdr_key_len;
            end
            else
            begin
                v.status         = (seen_count >= MAGIC_BYTES && magic_ok) ? STATUS_MALFORMED
                                                                           : STATUS_NOT_PROBE;
                v.transaction_id = '0;
                v.sender_key_len = '0;
            end
            verdict_queue.push_back(v);
            clear_header();
        end
    endtask

    // Queue a payload laid out as a probe header followed by random key bytes
    task automatic queue_probe(input logic [31:0] magic_word, input logic [7:0] ver,
                               input logic [7:0] ptype, input logic [15:0] len_field,
                               input logic [31:0] txn, input logic [7:0] key_len,
                               input int total, input bit drain);
        payload_byte_t pb;
        logic [7:0]    b;
        for (int i = 0; i < total; i++)
        begin
            if (i < 4)
                b = magic_word[31 - 8 * i -: 8];
            else if (i == 4)
                b = ver;
            else if (i == 5)
                b = ptype;
            else if (i == 6)
                b = len_field[15:8];
            else if (i == 7)
                b = len_field[7:0];
            else if (i >= 8 && i <= 11)
                b = txn[31 - 8 * (i - 8) -: 8];
            else if (i == 12)
                b = key_len;
            else
                b = 8'($urandom_range(0, 255));
            pb.data        = b;
            pb.last        = (i == total - 1);
            pb.drain_first = drain && (i == 0);
            byte_queue.push_back(pb);
        end
    endtask

    // Queue one random payload, mostly well-formed probes
    task automatic queue_random_packet();
        packet_kind_t kind;
        int           pick;
        int           total;
        logic [31:0]  magic_word;
        logic [7:0]   ver;
        logic [7:0]   ptype;
        logic [15:0]  len_field;
        logic [7:0]   key_len;
        bit           drain;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            kind = PK_GOOD;
        else if (pick < 60)
            kind = PK_BAD_MAGIC;
        else if (pick < 64)
            kind = PK_BAD_VERSION;
        else if (pick < 68)
            kind = PK_BAD_TYPE;
        else if (pick < 72)
            kind = PK_BAD_LENGTH;
        else if (pick < 76)
            kind = PK_BAD_KEYLEN;
        else if (pick < 82)
            kind = PK_SHORT;
        else if (pick < 87)
            kind = PK_LONG;
        else
            kind = PK_NOISE;

        magic_word = PROBE_MAGIC;
        ver        = PROBE_VERSION;
        ptype      = $urandom_range(0, 1) ? TYPE_RESPONSE : TYPE_REQUEST;
        key_len    = ($urandom_range(0, 29) == 0) ? 8'd255 : 8'($urandom_range(0, 24));
        total      = 16 + key_len;
        len_field  = 16'(total);
        drain      = ($urandom_range(0, 39) == 0);

        case (kind)
            PK_BAD_MAGIC:   magic_word = PROBE_MAGIC ^ (32'd1 << $urandom_range(0, 31));
            PK_BAD_VERSION: ver = PROBE_VERSION ^ 8'($urandom_range(1, 255));
            PK_BAD_TYPE:
            begin
                pick  = $urandom_range(0, 253);
                ptype = (pick == 0) ? 8'd0 : 8'(pick + 2);
            end
            PK_BAD_LENGTH:  len_field = len_field ^ 16'($urandom_range(1, 65535));
            PK_BAD_KEYLEN:  key_len = key_len ^ 8'($urandom_range(1, 255));
            PK_SHORT:       total = $urandom_range(1, 15);
            PK_LONG:
            begin
                total = total + $urandom_range(1, 8);
                if ($urandom_range(0, 1))
                    len_field = 16'(total);
            end
            PK_NOISE:
            begin
                magic_word = $urandom;
                ver        = 8'($urandom_range(0, 255));
                ptype      = 8'($urandom_range(0, 255));
                len_field  = 16'($urandom_range(0, 65535));
                key_len    = 8'($urandom_range(0, 255));
                total      = $urandom_range(1, 40);
            end
            default: ;
        endcase
        queue_probe(magic_word, ver, ptype, len_field, $urandom, key_len, total, drain);
    endtask

    // Compare returned verdicts, then predict from accepted bytes
    always @(posedge clk)
    begin : watch_ports
        verdict_t exp_v;
        if (rst_n && verdict_if.valid && verdict_if.ready)
        begin
            if (verdict_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected verdict: expected none, got status %0d txn %h key %0d",
                         $time, verdict_if.probe_status, verdict_if.transaction_id,
                         verdict_if.sender_key_len);
            end
            else
            begin
                exp_v = verdict_queue.pop_front();
                if (verdict_if.probe_status !== exp_v.status ||
                    verdict_if.transaction_id !== exp_v.transaction_id ||
                    verdict_if.sender_key_len !== exp_v.sender_key_len)
                begin
                    mismatch_count++;
                    $display("%0t: verdict mismatch: expected status %0d txn %h key %0d, got status %0d txn %h key %0d",
                             $time, exp_v.status, exp_v.transaction_id, exp_v.sender_key_len,
                             verdict_if.probe_status, verdict_if.transaction_id,
                             verdict_if.sender_key_len);
                end
            end
        end
        in_taken = rst_n && payload_if.valid && payload_if.ready;
        if (in_taken)
            parse_byte(payload_if.data_byte, payload_if.last_byte);
        cycle_cnt = cycle_cnt + 1;
    end

    // Send queued bytes in bursts; hold a request until it is taken
    always @(negedge clk)
    begin : drive_bytes
        logic present;
        present = 1'b0;
        if (rst_n)
        begin
            if (in_taken)
                void'(byte_queue.pop_front());
            if (payload_if.valid && !in_taken)
                present = 1'b1;
            else if (gap_left != 0)
                gap_left = gap_left - 1;
            else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain_first && verdict_queue.size() != 0))
            begin
                present = 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 32);
                burst_left = burst_left - 1;
                if (burst_left == 0)
                    gap_left = (cycle_cnt[10:9] == 2'b11) ? 0 : $urandom_range(0, 3);
            end
        end
        payload_if.valid <= present;
        if (present)
        begin
            payload_if.data_byte <= byte_queue[0].data;
            payload_if.last_byte <= byte_queue[0].last;
        end
        else
        begin
            payload_if.data_byte <= 8'($urandom_range(0, 255));
            payload_if.last_byte <= 1'($urandom_range(0, 1));
        end
    end

    // Stall the verdict channel in random stretches, with calm periods
    always @(negedge clk)
    begin
        if (!rst_n)
            verdict_if.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            verdict_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            verdict_if.ready <= 1'b1;
            if (cycle_cnt[11:10] != 2'b00 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
        end
    end

    // Bound the run
    initial
    begin
        #12_000_000;
        $display("punch_probe_header_parser_test: done, errors");
        $finish;
    end

    initial
    begin : run_test
        int start_size;
        int waited;
        rst_n                = 1'b0;
        payload_if.valid     = 1'b0;
        payload_if.data_byte = 8'd0;
        payload_if.last_byte = 1'b0;
        verdict_if.ready     = 1'b0;
        mismatch_count       = 0;
        in_taken             = 1'b0;
        cycle_cnt            = '0;
        burst_left           = 0;
        gap_left             = 0;
        stall_left           = 0;
        clear_header();

        // Runts and the bare magic
        queue_probe(PROBE_MAGIC, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 1, 1'b0);
        queue_probe(PROBE_MAGIC, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 3, 1'b0);
        queue_probe(PROBE_MAGIC, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 4, 1'b0);
        queue_probe(PROBE_MAGIC ^ 32'd1, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 4, 1'b0);
        // Valid probes at the field extremes
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_REQUEST, 16'd16, 32'hFFFF_FFFF, 8'd0,
                    16, 1'b0);
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_RESPONSE, 16'd271, 32'h0, 8'd255,
                    271, 1'b0);
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_REQUEST, 16'd23, $urandom, 8'd7,
                    23, 1'b1);
        // Bad version and type
        queue_probe(PROBE_MAGIC, 8'd0, TYPE_REQUEST, 16'd16, $urandom, 8'd0, 16, 1'b0);
        queue_probe(PROBE_MAGIC, 8'd255, TYPE_RESPONSE, 16'd16, $urandom, 8'd0, 16, 1'b0);
        queue_probe(PROBE_MAGIC, PROBE_VERSION, 8'd0, 16'd16, $urandom, 8'd0, 16, 1'b0);
        queue_probe(PROBE_MAGIC, PROBE_VERSION, 8'd3, 16'd16, $urandom, 8'd0, 16, 1'b0);
        queue_probe(PROBE_MAGIC, PROBE_VERSION, 8'd255, 16'd16, $urandom, 8'd0, 16, 1'b0);
        // Length and key length disagreeing with the count
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_REQUEST, 16'd21, $urandom, 8'd4,
                    20, 1'b0);
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_RESPONSE, 16'd20, $urandom, 8'd5,
                    20, 1'b0);
        // Short payloads leave later fields at reset
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_REQUEST, 16'd10, $urandom, 8'd0,
                    10, 1'b0);
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_REQUEST, 16'd13, $urandom, 8'd0,
                    13, 1'b0);
        // Magic broken at each offset
        for (int p = 0; p < 4; p++)
            queue_probe(PROBE_MAGIC ^ (32'hFF << (24 - 8 * p)), PROBE_VERSION, TYPE_REQUEST,
                        16'd16, $urandom, 8'd0, 16, 1'b0);
        // All-zero and all-ones headers
        queue_probe(32'h0, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 20, 1'b0);
        queue_probe(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 20, 1'b0);
        // A fresh probe after the corner cases
        queue_probe(PROBE_MAGIC, PROBE_VERSION, TYPE_RESPONSE, 16'd18, $urandom, 8'd2,
                    18, 1'b0);

        // Random traffic
        start_size = byte_queue.size();
        while (byte_queue.size() - start_size < RANDOM_BYTES)
            queue_random_packet();

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Drain the sender, then the outstanding verdicts
        while (byte_queue.size() != 0)
            @(posedge clk);
        waited = 0;
        while (verdict_queue.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        if (verdict_queue.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: missing verdicts: expected %0d more, got none",
                     $time, verdict_queue.size());
        end
        if (mismatch_count == 0)
            $display("punch_probe_header_parser_test: done, clean");
        else
            $display("punch_probe_header_parser_test: done, errors");
        $finish;
    end

endmodule

// ===== punch_probe_header_parser.f =====
src/pph_pkg.sv
src/pph_in_if.sv
src/pph_out_if.sv
src/pph_hdr_capture.sv
src/punch_probe_header_parser.sv
src/pph_checker.sv
tb/sv/punch_probe_header_parser_test.sv
